// File: rtl/prre_pkg.sv
// Shared types, constants and helpers of the Phong ramp reflection pipeline.
`timescale 1ns / 1ps

package prre_pkg;

    localparam int MAX_COLORS_DEF = 8;
    localparam int PAIR_COUNT     = 4;
    localparam int CH_W           = 10;
    localparam int PAIR_W         = 6 * CH_W;
    localparam int CFG_W          = PAIR_W;
    localparam int CFG_IDX_W      = 3;
    localparam int EXP_W          = 16;
    localparam int CC_W           = 4;
    localparam int VEC_W          = 16;
    localparam int DOT_W          = 2 * VEC_W + 2;
    localparam int NI_W           = 18;
    localparam int X_W            = 31;
    localparam int FRAC_SHIFT     = 30;
    localparam int INT_BITS       = 8;
    localparam int FRAC_BITS      = 8;
    localparam int OUT_W          = 24;
    localparam int COMMON_W       = 30;
    localparam int COL_W          = 18;
    localparam int DENS_W         = 23;
    localparam int W24_W          = 31;
    localparam int WEIGHT_W       = 25;

    localparam logic [X_W-1:0]      ONE_Q30     = X_W'(1) << FRAC_SHIFT;
    localparam logic [COMMON_W-1:0] INV_2PI_Q32 = COMMON_W'(683565276);

    // Pipelined floor square root: 31 root bits, four per stage.
    localparam int SQRT_BITS      = 31;
    localparam int SQRT_IN_W      = 2 * SQRT_BITS;
    localparam int SQRT_REM_W     = SQRT_BITS + 3;
    localparam int SQRT_PER_STAGE = 4;
    localparam int SQRT_STAGES    = (SQRT_BITS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPONENT    = 3'd0,
        CFG_COLOR_COUNT = 3'd1,
        CFG_PAIR_0      = 3'd2,
        CFG_PAIR_1      = 3'd3,
        CFG_PAIR_2      = 3'd4,
        CFG_PAIR_3      = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } vec_t;

    typedef struct packed {
        vec_t normal;
        vec_t view;
        vec_t light;
        logic flip_side;
    } item_t;

    typedef struct packed {
        logic            lit;
        logic [NI_W-1:0] ni16;
    } side_t;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
        logic [OUT_W-1:0] density;
        logic             lit;
    } result_t;

    // Channel 0 is red, in the low bits.
    typedef logic [2:0][CH_W-1:0] color_t;

    function automatic logic signed [DOT_W-1:0] dot3(vec_t a, vec_t b);
        logic signed [2*VEC_W-1:0] px;
        logic signed [2*VEC_W-1:0] py;
        logic signed [2*VEC_W-1:0] pz;
        px = a.x * b.x;
        py = a.y * b.y;
        pz = a.z * b.z;
        return $signed({{2{px[2*VEC_W-1]}}, px}) + $signed({{2{py[2*VEC_W-1]}}, py})
             + $signed({{2{pz[2*VEC_W-1]}}, pz});
    endfunction

endpackage

// File: rtl/prre_geom.sv
// Dot products, hemisphere tests and reflected cosine, three stages.
`timescale 1ns / 1ps

module prre_geom (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  prre_pkg::item_t          in_item,
    output logic                     out_valid,
    output logic [prre_pkg::X_W-1:0] out_x,
    output prre_pkg::side_t          out_side
);

    localparam int DW = prre_pkg::DOT_W;
    localparam int NW = prre_pkg::NI_W;
    localparam int PW = 2 * NW;

    // stage 1
    logic                 s1_valid_reg;
    logic                 s1_flip_reg;
    logic signed [DW-1:0] s1_dnl_reg;
    logic signed [DW-1:0] s1_dnv_reg;
    logic signed [DW-1:0] s1_dvl_reg;

    // stage 2
    logic signed [DW-1:0] cni;
    logic signed [DW-1:0] cno;
    logic                 ok_next;
    logic [NW-1:0]        ni16;
    logic [NW-1:0]        no16;
    logic                 s2_valid_reg;
    logic                 s2_ok_reg;
    logic [PW-1:0]        s2_prod_reg;
    logic signed [DW-1:0] s2_dvl_reg;
    logic [NW-1:0]        s2_ni16_reg;

    // stage 3
    logic signed [PW:0]          cri;
    logic                        lit_next;
    logic [prre_pkg::X_W-1:0]    x_next;
    logic                        s3_valid_reg;
    logic [prre_pkg::X_W-1:0]    s3_x_reg;
    prre_pkg::side_t             s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_flip_reg <= in_item.flip_side;
            s1_dnl_reg  <= prre_pkg::dot3(in_item.normal, in_item.light);
            s1_dnv_reg  <= prre_pkg::dot3(in_item.normal, in_item.view);
            s1_dvl_reg  <= prre_pkg::dot3(in_item.view, in_item.light);
        end
    end

    always_comb
    begin
        cni     = s1_flip_reg ? -s1_dnl_reg : s1_dnl_reg;
        cno     = s1_flip_reg ? -s1_dnv_reg : s1_dnv_reg;
        ok_next = !cni[DW-1] && (cni != '0) && !cno[DW-1] && (cno != '0);
        // both cosines stay below 2^32 when positive
        ni16    = cni[NW+13:14];
        no16    = cno[NW+13:14];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_ok_reg   <= ok_next;
            s2_prod_reg <= ni16 * no16;
            s2_dvl_reg  <= s1_dvl_reg;
            s2_ni16_reg <= ni16;
        end
    end

    always_comb
    begin
        cri      = $signed({2'b00, s2_prod_reg[PW-1:1]})
                 - $signed({{(PW+1-DW){s2_dvl_reg[DW-1]}}, s2_dvl_reg});
        lit_next = s2_ok_reg && !cri[PW] && (cri != '0);
        if (!lit_next)
            x_next = '0;
        else if (cri[PW-1:0] > PW'(prre_pkg::ONE_Q30))
            x_next = prre_pkg::ONE_Q30;      // saturate cosine above one
        else
            x_next = cri[prre_pkg::X_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_x_reg         <= x_next;
            s3_side_reg.lit  <= lit_next;
            s3_side_reg.ni16 <= s2_ni16_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_x     = s3_x_reg;
    assign out_side  = s3_side_reg;

endmodule

// File: rtl/prre_isqrt.sv
// Pipelined floor square root, a few root bits per stage.
`timescale 1ns / 1ps

module prre_isqrt (
    input  logic                           clk,
    input  logic                           en,
    input  logic [prre_pkg::SQRT_IN_W-1:0] radicand,
    output logic [prre_pkg::SQRT_BITS-1:0] root
);

    localparam int NB  = prre_pkg::SQRT_BITS;
    localparam int IW  = prre_pkg::SQRT_IN_W;
    localparam int RW  = prre_pkg::SQRT_REM_W;
    localparam int PS  = prre_pkg::SQRT_PER_STAGE;
    localparam int NS  = prre_pkg::SQRT_STAGES;

    logic [RW-1:0] rem_b  [NS+1];
    logic [NB-1:0] root_b [NS+1];
    logic [IW-1:0] rad_b  [NS+1];

    assign rem_b[0]  = '0;
    assign root_b[0] = '0;
    assign rad_b[0]  = radicand;

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        logic [RW-1:0] c_rem;
        logic [NB-1:0] c_root;
        logic [IW-1:0] c_rad;
        logic [RW-1:0] c_trial;
        logic [RW-1:0] rem_reg;
        logic [NB-1:0] root_reg;
        logic [IW-1:0] rad_reg;

        always_comb
        begin
            c_rem   = rem_b[g];
            c_root  = root_b[g];
            c_rad   = rad_b[g];
            c_trial = '0;
            for (int j = 0; j < PS; j++)
            begin
                if (g * PS + j < NB)
                begin
                    // bring down the next two radicand bits
                    c_rem   = {c_rem[RW-3:0], c_rad[IW-1 -: 2]};
                    c_rad   = {c_rad[IW-3:0], 2'b00};
                    c_trial = {1'b0, c_root, 2'b01};
                    if (c_rem >= c_trial)
                    begin
                        c_rem  = c_rem - c_trial;
                        c_root = {c_root[NB-2:0], 1'b1};
                    end
                    else
                    begin
                        c_root = {c_root[NB-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= c_rem;
                root_reg <= c_root;
                rad_reg  <= c_rad;
            end
        end

        assign rem_b[g+1]  = rem_reg;
        assign root_b[g+1] = root_reg;
        assign rad_b[g+1]  = rad_reg;
    end

    assign root = root_b[NS];

endmodule

// File: rtl/prre_pow.sv
// Cosine raised to a Q8.8 exponent: square-and-multiply, then root chain.
`timescale 1ns / 1ps

module prre_pow (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [prre_pkg::EXP_W-1:0] exponent,
    input  logic                       in_valid,
    input  logic [prre_pkg::X_W-1:0]   in_x,
    input  prre_pkg::side_t            in_side,
    output logic                       out_valid,
    output logic [prre_pkg::X_W-1:0]   out_p,
    output prre_pkg::side_t            out_side
);

    localparam int XW = prre_pkg::X_W;
    localparam int SH = prre_pkg::FRAC_SHIFT;
    localparam int NI = prre_pkg::INT_BITS;
    localparam int NF = prre_pkg::FRAC_BITS;
    localparam int NS = prre_pkg::SQRT_STAGES;

    // integer exponent bits, low to high
    logic                  iv    [NI+1];
    logic [XW-1:0]         ir    [NI+1];
    logic [XW-1:0]         ib    [NI+1];
    logic [XW-1:0]         ix    [NI+1];
    prre_pkg::side_t       iside [NI+1];

    assign iv[0]    = in_valid;
    assign ir[0]    = prre_pkg::ONE_Q30;
    assign ib[0]    = in_x;
    assign ix[0]    = in_x;
    assign iside[0] = in_side;

    for (genvar g = 0; g < NI; g++)
    begin : g_int
        logic [2*XW-1:0] rb;
        logic [2*XW-1:0] bb;
        logic [XW-1:0]   r_next;
        logic            valid_reg;
        logic [XW-1:0]   r_reg;
        logic [XW-1:0]   b_reg;
        logic [XW-1:0]   x_reg;
        prre_pkg::side_t side_reg;

        assign rb     = ir[g] * ib[g];
        assign bb     = ib[g] * ib[g];
        assign r_next = exponent[NF+g] ? rb[SH+XW-1:SH] : ir[g];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else if (en)
                valid_reg <= iv[g];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg    <= r_next;
                b_reg    <= bb[SH+XW-1:SH];
                x_reg    <= ix[g];
                side_reg <= iside[g];
            end
        end

        assign iv[g+1]    = valid_reg;
        assign ir[g+1]    = r_reg;
        assign ib[g+1]    = b_reg;
        assign ix[g+1]    = x_reg;
        assign iside[g+1] = side_reg;
    end

    // fractional bits: weight one half first, each root taken of the last
    logic            fv    [NF+1];
    logic [XW-1:0]   fr    [NF+1];
    logic [XW-1:0]   fs    [NF+1];
    prre_pkg::side_t fside [NF+1];

    assign fv[0]    = iv[NI];
    assign fr[0]    = ir[NI];
    assign fs[0]    = ix[NI];
    assign fside[0] = iside[NI];

    for (genvar g = 0; g < NF; g++)
    begin : g_frac
        logic [XW-1:0]   root;
        logic [NS-1:0]   dv_reg;
        logic [XW-1:0]   dr_reg    [NS];
        prre_pkg::side_t dside_reg [NS];
        logic [2*XW-1:0] rs;
        logic [XW-1:0]   r_next;
        logic            valid_reg;
        logic [XW-1:0]   r_reg;
        logic [XW-1:0]   s_reg;
        prre_pkg::side_t side_reg;

        prre_isqrt u_isqrt (
            .clk      (clk),
            .en       (en),
            .radicand ({1'b0, fs[g], SH'(0)}),
            .root     (root)
        );

        // hold the partial power alongside the root pipeline
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg <= '0;
            else if (en)
                dv_reg <= {dv_reg[NS-2:0], fv[g]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dr_reg[0]    <= fr[g];
                dside_reg[0] <= fside[g];
                for (int i = 1; i < NS; i++)
                begin
                    dr_reg[i]    <= dr_reg[i-1];
                    dside_reg[i] <= dside_reg[i-1];
                end
            end
        end

        assign rs     = dr_reg[NS-1] * root;
        assign r_next = exponent[NF-1-g] ? rs[SH+XW-1:SH] : dr_reg[NS-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else if (en)
                valid_reg <= dv_reg[NS-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg    <= r_next;
                s_reg    <= root;
                side_reg <= dside_reg[NS-1];
            end
        end

        assign fv[g+1]    = valid_reg;
        assign fr[g+1]    = r_reg;
        assign fs[g+1]    = s_reg;
        assign fside[g+1] = side_reg;
    end

    assign out_valid = fv[NF];
    assign out_p     = fr[NF];
    assign out_side  = fside[NF];

endmodule

// File: rtl/prre_shade.sv
// Lobe normalization, ramp color blend and channel weights, four stages.
`timescale 1ns / 1ps

module prre_shade #(
    parameter int MAX_COLORS = prre_pkg::MAX_COLORS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic [prre_pkg::EXP_W-1:0]          exponent,
    input  logic [((MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1)-1:0] n_m1,
    input  prre_pkg::color_t                    colors [MAX_COLORS],
    input  logic                                in_valid,
    input  logic [prre_pkg::X_W-1:0]            in_p,
    input  prre_pkg::side_t                     in_side,
    output logic                                out_valid,
    output prre_pkg::result_t                   out_result
);

    localparam int IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
    localparam int XW    = prre_pkg::X_W;
    localparam int SH    = prre_pkg::FRAC_SHIFT;
    localparam int NPW   = XW + IDX_W;
    localparam int CW    = prre_pkg::COMMON_W;
    localparam int EW    = prre_pkg::EXP_W + 1;
    localparam int CLW   = prre_pkg::COL_W;
    localparam int NW    = prre_pkg::NI_W;
    localparam int WW    = prre_pkg::WEIGHT_W;
    localparam int OW    = prre_pkg::OUT_W;
    localparam int HW    = prre_pkg::CH_W;

    // stage A
    logic [XW+CW-1:0]      common_prod;
    logic                  a_valid_reg;
    logic [CW-1:0]         a_common_reg;
    logic [NPW-1:0]        a_npos_reg;
    prre_pkg::side_t       a_side_reg;

    // stage B
    logic [EW-1:0]         e_dens;
    logic [EW-1:0]         e_wgt;
    logic [CW+EW-1:0]      dens_prod;
    logic [CW+EW-1:0]      wgt_prod;
    logic [NPW-SH-1:0]     ipos;
    logic [15:0]           frac;
    logic [IDX_W-1:0]      lo_idx;
    logic [IDX_W-1:0]      hi_idx;
    logic [CLW-1:0]        col_next [3];
    logic [HW+17-1:0]      blend;
    logic                  b_valid_reg;
    logic [prre_pkg::DENS_W-1:0] b_dens_reg;
    logic [prre_pkg::W24_W-1:0]  b_w24_reg;
    logic [CLW-1:0]        b_col_reg [3];
    prre_pkg::side_t       b_side_reg;

    // stage C
    logic [prre_pkg::W24_W+NW-1:0] wprod;
    logic                  c_valid_reg;
    logic [WW-1:0]         c_weight_reg;
    logic [CLW-1:0]        c_col_reg [3];
    logic [prre_pkg::DENS_W-1:0] c_dens_reg;
    logic                  c_lit_reg;

    // stage D
    logic [WW+CLW-1:0]     chprod [3];
    logic [OW-1:0]         ch_sat [3];
    prre_pkg::result_t     res_next;
    logic                  d_valid_reg;
    prre_pkg::result_t     d_result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    assign common_prod = in_p * prre_pkg::INV_2PI_Q32;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_common_reg <= common_prod[SH+CW-1:SH];
            a_npos_reg   <= in_p * n_m1;
            a_side_reg   <= in_side;
        end
    end

    always_comb
    begin
        e_dens    = {1'b0, exponent} + EW'(256);
        e_wgt     = {1'b0, exponent} + EW'(512);
        dens_prod = a_common_reg * e_dens;
        wgt_prod  = a_common_reg * e_wgt;
        ipos      = a_npos_reg[NPW-1:SH];
        frac      = a_npos_reg[SH-1:SH-16];
        lo_idx    = ipos[IDX_W-1:0];
        hi_idx    = IDX_W'(ipos + 1'b1);
        blend     = '0;
        for (int c = 0; c < 3; c++)
        begin
            if (ipos >= (NPW-SH)'(n_m1))
            begin
                // past the last segment: last color alone
                col_next[c] = {colors[n_m1][c], 8'b0};
            end
            else
            begin
                blend = colors[lo_idx][c] * (17'd65536 - {1'b0, frac})
                      + colors[hi_idx][c] * {1'b0, frac};
                col_next[c] = blend[CLW+7:8];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_dens_reg <= dens_prod[prre_pkg::DENS_W+23:24];
            b_w24_reg  <= wgt_prod[prre_pkg::W24_W+15:16];
            b_side_reg <= a_side_reg;
            for (int c = 0; c < 3; c++)
                b_col_reg[c] <= col_next[c];
        end
    end

    assign wprod = b_w24_reg * b_side_reg.ni16;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_weight_reg <= wprod[WW+23:24];
            c_dens_reg   <= b_dens_reg;
            c_lit_reg    <= b_side_reg.lit;
            for (int c = 0; c < 3; c++)
                c_col_reg[c] <= b_col_reg[c];
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            chprod[c] = c_weight_reg * c_col_reg[c];
            ch_sat[c] = (chprod[c][WW+CLW-1:OW+16] != '0) ? '1 : chprod[c][OW+15:16];
        end
        res_next.red     = c_lit_reg ? ch_sat[0] : '0;
        res_next.green   = c_lit_reg ? ch_sat[1] : '0;
        res_next.blue    = c_lit_reg ? ch_sat[2] : '0;
        res_next.density = c_lit_reg ? OW'(c_dens_reg) : '0;
        res_next.lit     = c_lit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_result_reg <= res_next;
    end

    assign out_valid  = d_valid_reg;
    assign out_result = d_result_reg;

endmodule

// File: rtl/phong_ramp_reflect_eval.sv
// Top level: configuration registers, pipeline and output skid stage.
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// in       in_valid / in_stall  normal_*, view_*, light_*, flip_side
// out      out_valid/ out_stall red, green, blue, density, lit
// cfg      cfg_write            cfg_index, cfg_data
//
// One item per cycle while the skid register is empty; an item passes 3 geometry stages,
// 8 square-and-multiply stages, 8 root steps of 9 stages each (8-stage
// square root plus a multiply), 4 shading stages and the output register.
// Reset clears all valid bits and loads the register reset values.
// A stalled output parks one extra item in the skid register; the input
// stalls only while that register is full.

module phong_ramp_reflect_eval #(
    parameter int MAX_COLORS = prre_pkg::MAX_COLORS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [15:0]             normal_x,
    input  logic signed [15:0]             normal_y,
    input  logic signed [15:0]             normal_z,
    input  logic signed [15:0]             view_x,
    input  logic signed [15:0]             view_y,
    input  logic signed [15:0]             view_z,
    input  logic signed [15:0]             light_x,
    input  logic signed [15:0]             light_y,
    input  logic signed [15:0]             light_z,
    input  logic                           flip_side,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [23:0]                    red,
    output logic [23:0]                    green,
    output logic [23:0]                    blue,
    output logic [23:0]                    density,
    output logic                           lit,
    input  logic                           cfg_write,
    input  logic [prre_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [prre_pkg::CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;

    logic [prre_pkg::EXP_W-1:0]  exponent_reg;
    logic [prre_pkg::CC_W-1:0]   color_count_reg;
    logic [prre_pkg::PAIR_W-1:0] pair_reg [prre_pkg::PAIR_COUNT];
    logic [IDX_W-1:0]            n_m1;
    prre_pkg::color_t            colors [MAX_COLORS];

    prre_pkg::item_t             item;
    logic                        en;
    logic                        g_valid;
    logic [prre_pkg::X_W-1:0]    g_x;
    prre_pkg::side_t             g_side;
    logic                        p_valid;
    logic [prre_pkg::X_W-1:0]    p_p;
    prre_pkg::side_t             p_side;
    logic                        s_valid;
    prre_pkg::result_t           s_result;

    logic                        push;
    logic                        pop;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        skid_valid_reg;
    logic                        skid_valid_next;
    prre_pkg::result_t           out_reg;
    prre_pkg::result_t           out_next;
    prre_pkg::result_t           skid_reg;
    prre_pkg::result_t           skid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg    <= prre_pkg::EXP_W'(256);
            color_count_reg <= prre_pkg::CC_W'(1);
            for (int i = 0; i < prre_pkg::PAIR_COUNT; i++)
                pair_reg[i] <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                prre_pkg::CFG_EXPONENT:    exponent_reg    <= cfg_data[prre_pkg::EXP_W-1:0];
                prre_pkg::CFG_COLOR_COUNT: color_count_reg <= cfg_data[prre_pkg::CC_W-1:0];
                prre_pkg::CFG_PAIR_0:      pair_reg[0]     <= cfg_data;
                prre_pkg::CFG_PAIR_1:      pair_reg[1]     <= cfg_data;
                prre_pkg::CFG_PAIR_2:      pair_reg[2]     <= cfg_data;
                prre_pkg::CFG_PAIR_3:      pair_reg[3]     <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // zero colors acts as one, too many clamps to the ramp size
    always_comb
    begin
        if (color_count_reg == '0)
            n_m1 = '0;
        else if (color_count_reg > prre_pkg::CC_W'(MAX_COLORS))
            n_m1 = IDX_W'(MAX_COLORS - 1);
        else
            n_m1 = IDX_W'(color_count_reg - 1'b1);
    end

    for (genvar i = 0; i < MAX_COLORS; i++)
    begin : g_color
        assign colors[i] = pair_reg[(i / 2) % prre_pkg::PAIR_COUNT][(i % 2) * 30 +: 30];
    end

    assign item.normal.x  = normal_x;
    assign item.normal.y  = normal_y;
    assign item.normal.z  = normal_z;
    assign item.view.x    = view_x;
    assign item.view.y    = view_y;
    assign item.view.z    = view_z;
    assign item.light.x   = light_x;
    assign item.light.y   = light_y;
    assign item.light.z   = light_z;
    assign item.flip_side = flip_side;

    // the whole pipeline advances unless the skid register is occupied
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    prre_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_item   (item),
        .out_valid (g_valid),
        .out_x     (g_x),
        .out_side  (g_side)
    );

    prre_pow u_pow (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .exponent  (exponent_reg),
        .in_valid  (g_valid),
        .in_x      (g_x),
        .in_side   (g_side),
        .out_valid (p_valid),
        .out_p     (p_p),
        .out_side  (p_side)
    );

    prre_shade #(
        .MAX_COLORS (MAX_COLORS)
    ) u_shade (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .exponent   (exponent_reg),
        .n_m1       (n_m1),
        .colors     (colors),
        .in_valid   (p_valid),
        .in_p       (p_p),
        .in_side    (p_side),
        .out_valid  (s_valid),
        .out_result (s_result)
    );

    assign push = s_valid && en;
    assign pop  = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = s_result;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            // output held: park the item
            skid_next       = s_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign red       = out_reg.red;
    assign green     = out_reg.green;
    assign blue      = out_reg.blue;
    assign density   = out_reg.density;
    assign lit       = out_reg.lit;

endmodule
